// ----- design/hrm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants for the heart rate monitor.
// Used by every module of the block but hrm_fifo; depends on nothing.
package hrm_pkg;

    localparam int SAMPLE_BITS     = 10;
    localparam int RATE_BITS       = 10;
    localparam int PERIOD_BITS     = 16;
    localparam int COUNT_BITS      = 16;
    localparam int SUM_BITS        = 32;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int RES_QUEUE_DEPTH = 2;

    localparam logic [SUM_BITS-1:0]    MS_PER_MINUTE = SUM_BITS'(60000);
    localparam logic [RATE_BITS-1:0]   RATE_MAX      = '1;
    localparam logic [PERIOD_BITS-1:0] PERIOD_MAX    = '1;
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX     = '1;

    // input function codes
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_SAMPLE = 2'd1;
    localparam logic [1:0] FUNC_END    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_BEAT_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_PERIOD       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_INCLUSIVE    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_PERIOD       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_BPM          = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_BPM         = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ABNORMAL_MIN_PER = 3'd6;

    typedef struct packed {
        logic [1:0]             func;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   leads_on;
    } t_in_item;

    typedef struct packed {
        logic                   beat;
        logic                   lead_fault;
        logic [RATE_BITS-1:0]   bpm;
        logic                   alarm;
        logic [COUNT_BITS-1:0]  abnormal_count;
        logic [RATE_BITS-1:0]   average_bpm;
        logic                   average_valid;
    } t_out_item;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] beat_threshold;
        logic [PERIOD_BITS-1:0] min_period_ms;
        logic                   min_period_inclusive;
        logic [PERIOD_BITS-1:0] max_period_ms;
        logic [RATE_BITS-1:0]   low_bpm_limit;
        logic [RATE_BITS-1:0]   high_bpm_limit;
        logic [PERIOD_BITS-1:0] abnormal_min_period_ms;
    } t_cfg;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_CROSS,
        OP_QUIET,
        OP_END,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op  op;
        logic leads_on;
    } t_cmd;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_DIV
    } t_bstate;

    function automatic logic [RATE_BITS-1:0] sat_rate(input logic [SUM_BITS-1:0] q);
        sat_rate = (|q[SUM_BITS-1:RATE_BITS]) ? RATE_MAX : q[RATE_BITS-1:0];
    endfunction

endpackage

// ----- design/hrm_fifo.sv -----
`timescale 1ns / 1ps
// Small register queue used between front and back and on the result side.
// Generic in width and depth; no package dependency.
module hrm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- design/hrm_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by rate and average.
// Uses hrm_pkg widths. A zero divisor gives an all-ones quotient.
module hrm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [hrm_pkg::SUM_BITS-1:0]  i_dividend,
    input  logic [hrm_pkg::COUNT_BITS-1:0] i_divisor,
    output logic                          o_done,
    output logic [hrm_pkg::SUM_BITS-1:0]  o_quotient
);
    import hrm_pkg::*;

    localparam int STEP_W = $clog2(SUM_BITS);

    logic                  r_busy, r_done;
    logic [STEP_W-1:0]     r_step;
    logic [COUNT_BITS-1:0] r_divisor;
    logic [COUNT_BITS-1:0] r_rem;
    logic [SUM_BITS-1:0]   r_quo;
    logic [COUNT_BITS:0]   w_rem_sh;
    logic                  w_ge;
    logic [COUNT_BITS:0]   w_diff;

    assign w_rem_sh   = {r_rem, r_quo[SUM_BITS-1]};
    assign w_ge       = (w_rem_sh >= {1'b0, r_divisor});
    assign w_diff     = w_rem_sh - {1'b0, r_divisor};
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(SUM_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_divisor <= i_divisor;
            r_rem     <= '0;
            r_quo     <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[COUNT_BITS-1:0] : w_rem_sh[COUNT_BITS-1:0];
            r_quo <= {r_quo[SUM_BITS-2:0], w_ge};
        end
    end

endmodule

// ----- design/hrm_front.sv -----
`timescale 1ns / 1ps
// Front part: accepts input items, classifies them against the threshold
// and queues the resulting commands. Depends on hrm_pkg and hrm_fifo.
module hrm_front #(
    parameter int DEPTH = hrm_pkg::CMD_QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  hrm_pkg::t_in_item                 i_item,
    output logic                              o_full,
    input  logic [hrm_pkg::SAMPLE_BITS-1:0]   i_threshold,
    input  logic                              i_cmd_pop,
    output hrm_pkg::t_cmd                     o_cmd,
    output logic                              o_cmd_empty
);
    import hrm_pkg::*;

    t_cmd                w_cmd;
    logic [$bits(t_cmd)-1:0] w_cmd_bits;

    always_comb begin
        w_cmd.leads_on = i_item.leads_on;
        unique case (i_item.func)
            FUNC_TICK:   w_cmd.op = OP_TICK;
            FUNC_SAMPLE: w_cmd.op = (i_item.sample > i_threshold) ? OP_CROSS : OP_QUIET;
            FUNC_END:    w_cmd.op = OP_END;
            default:     w_cmd.op = OP_NOP;
        endcase
    end

    hrm_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (w_cmd_bits),
        .o_empty (o_cmd_empty)
    );

    assign o_cmd = t_cmd'(w_cmd_bits);

endmodule

// ----- design/hrm_back.sv -----
`timescale 1ns / 1ps
// Back part: holds the monitor state, runs each command and builds its result.
// Depends on hrm_pkg and hrm_div.
module hrm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hrm_pkg::t_cfg      i_cfg,
    input  hrm_pkg::t_cmd      i_cmd,
    input  logic               i_cmd_empty,
    output logic               o_cmd_pop,
    input  logic               i_res_full,
    output logic               o_res_push,
    output hrm_pkg::t_out_item o_res
);
    import hrm_pkg::*;

    t_bstate               r_state, n_state;
    logic                  r_armed, n_armed;
    logic                  r_have_first, n_have_first;
    logic [PERIOD_BITS-1:0] r_ms, n_ms;
    logic [RATE_BITS-1:0]  r_rate, n_rate;
    logic                  r_alarm, n_alarm;
    logic [COUNT_BITS-1:0] r_abn, n_abn;
    logic [COUNT_BITS-1:0] r_beats, n_beats;
    logic [SUM_BITS-1:0]   r_sum, n_sum;
    logic [PERIOD_BITS-1:0] r_period, n_period;
    logic                  r_is_end, n_is_end;

    logic                  w_div_start, w_div_done;
    logic [SUM_BITS-1:0]   w_dividend, w_quotient;
    logic [COUNT_BITS-1:0] w_divisor;
    logic                  w_lo_ok, w_in_window;
    logic                  v_judge, v_measured, v_beat_fin, v_end;
    logic [PERIOD_BITS-1:0] v_period;

    assign w_lo_ok     = i_cfg.min_period_inclusive ? (r_ms >= i_cfg.min_period_ms)
                                                    : (r_ms > i_cfg.min_period_ms);
    assign w_in_window = w_lo_ok && (r_ms < i_cfg.max_period_ms);

    hrm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BS_IDLE;
            r_armed      <= 1'b1;
            r_have_first <= 1'b0;
            r_ms         <= '0;
            r_rate       <= '0;
            r_alarm      <= 1'b0;
            r_abn        <= '0;
            r_beats      <= '0;
            r_sum        <= '0;
            r_is_end     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_armed      <= n_armed;
            r_have_first <= n_have_first;
            r_ms         <= n_ms;
            r_rate       <= n_rate;
            r_alarm      <= n_alarm;
            r_abn        <= n_abn;
            r_beats      <= n_beats;
            r_sum        <= n_sum;
            r_is_end     <= n_is_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_period <= n_period;
    end

    always_comb begin
        n_state      = r_state;
        n_armed      = r_armed;
        n_have_first = r_have_first;
        n_ms         = r_ms;
        n_rate       = r_rate;
        n_alarm      = r_alarm;
        n_abn        = r_abn;
        n_beats      = r_beats;
        n_sum        = r_sum;
        n_period     = r_period;
        n_is_end     = r_is_end;
        o_cmd_pop    = 1'b0;
        o_res_push   = 1'b0;
        o_res        = '0;
        w_div_start  = 1'b0;
        w_dividend   = MS_PER_MINUTE;
        w_divisor    = r_ms;
        v_judge      = 1'b0;
        v_measured   = 1'b0;
        v_beat_fin   = 1'b0;
        v_end        = 1'b0;
        v_period     = r_ms;

        unique case (r_state)
            BS_IDLE: begin
                if (!i_cmd_empty && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        OP_TICK: begin
                            o_res_push = 1'b1;
                            if (r_ms != PERIOD_MAX) begin
                                n_ms = r_ms + 1'b1;
                            end
                        end
                        OP_QUIET: begin
                            o_res_push = 1'b1;
                            n_armed    = 1'b1;
                        end
                        OP_CROSS: begin
                            o_res_push = 1'b1;
                            if (r_armed) begin
                                n_armed = 1'b0;
                                if (!i_cmd.leads_on) begin
                                    o_res.lead_fault = 1'b1;
                                    v_judge          = 1'b1;
                                end else if (!r_have_first) begin
                                    o_res.beat   = 1'b1;
                                    n_have_first = 1'b1;
                                    n_ms         = '0;
                                    v_judge      = 1'b1;
                                end else if (w_in_window) begin
                                    // hold the result until the rate is divided out
                                    o_res_push  = 1'b0;
                                    w_div_start = 1'b1;
                                    n_period    = r_ms;
                                    n_is_end    = 1'b0;
                                    n_state     = BS_DIV;
                                end else begin
                                    o_res.beat = 1'b1;
                                    v_beat_fin = 1'b1;
                                end
                            end
                        end
                        OP_END: begin
                            if (r_beats != '0) begin
                                w_div_start = 1'b1;
                                w_dividend  = r_sum;
                                w_divisor   = r_beats;
                                n_is_end    = 1'b1;
                                n_state     = BS_DIV;
                            end else begin
                                o_res_push = 1'b1;
                                v_end      = 1'b1;
                            end
                        end
                        default: begin
                            o_res_push = 1'b1;
                        end
                    endcase
                end
            end
            BS_DIV: begin
                if (w_div_done) begin
                    o_res_push = 1'b1;
                    n_state    = BS_IDLE;
                    if (r_is_end) begin
                        v_end               = 1'b1;
                        o_res.average_bpm   = sat_rate(w_quotient);
                        o_res.average_valid = 1'b1;
                    end else begin
                        o_res.beat = 1'b1;
                        n_rate     = sat_rate(w_quotient);
                        v_beat_fin = 1'b1;
                        v_period   = r_period;
                    end
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase

        if (v_beat_fin) begin
            if (r_beats != COUNT_MAX) begin
                n_beats = r_beats + 1'b1;
                n_sum   = r_sum + SUM_BITS'(n_rate);
            end
            n_ms       = '0;
            v_judge    = 1'b1;
            v_measured = 1'b1;
        end

        if (v_judge) begin
            if (n_rate < i_cfg.low_bpm_limit || n_rate > i_cfg.high_bpm_limit) begin
                if (v_measured && v_period > i_cfg.abnormal_min_period_ms) begin
                    n_alarm = 1'b1;
                    if (r_abn != COUNT_MAX) begin
                        n_abn = r_abn + 1'b1;
                    end
                end
            end else begin
                n_alarm = 1'b0;
            end
        end

        o_res.bpm            = n_rate;
        o_res.alarm          = n_alarm;
        o_res.abnormal_count = n_abn;

        // show the session before it is cleared
        if (v_end) begin
            o_res.bpm            = r_rate;
            o_res.alarm          = r_alarm;
            o_res.abnormal_count = r_abn;
            n_rate               = '0;
            n_alarm              = 1'b0;
            n_abn                = '0;
            n_beats              = '0;
            n_sum                = '0;
            n_ms                 = '0;
            n_have_first         = 1'b0;
        end
    end

endmodule

// ----- design/ecg_heart_rate_monitor_unit.sv -----
`timescale 1ns / 1ps
// ECG heart rate monitor: ticks, samples and end-of-session commands enter a
// command queue, the back part runs them one at a time into a result queue.
// Ticks, samples and unknown commands are handled in the idle state, so a queue
// item follows every cycle while the result queue has room. A beat whose period
// is in the window, and an end of session with at least one counted beat, go
// through the shared 32-step restoring divider; no other item is started
// meanwhile. Configuration writes are always ready and take effect at once;
// write only while idle. Depends on hrm_pkg, hrm_front, hrm_back, hrm_fifo.
module ecg_heart_rate_monitor_unit #(
    parameter int CMD_DEPTH = hrm_pkg::CMD_QUEUE_DEPTH,
    parameter int RES_DEPTH = hrm_pkg::RES_QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  hrm_pkg::t_in_item                   i_item,
    output logic                                empty,
    input  logic                                pop,
    output hrm_pkg::t_out_item                  o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hrm_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [hrm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import hrm_pkg::*;

    t_cfg                        r_cfg;
    t_cmd                        w_cmd;
    logic                        w_cmd_empty, w_cmd_pop;
    logic                        w_res_full, w_res_push;
    t_out_item                   w_res;
    logic [$bits(t_out_item)-1:0] w_res_bits;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.beat_threshold         <= SAMPLE_BITS'(500);
            r_cfg.min_period_ms          <= PERIOD_BITS'(600);
            r_cfg.min_period_inclusive   <= 1'b0;
            r_cfg.max_period_ms          <= PERIOD_BITS'(1000);
            r_cfg.low_bpm_limit          <= RATE_BITS'(60);
            r_cfg.high_bpm_limit         <= RATE_BITS'(120);
            r_cfg.abnormal_min_period_ms <= PERIOD_BITS'(600);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BEAT_THRESHOLD:   r_cfg.beat_threshold <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_MIN_PERIOD:       r_cfg.min_period_ms <= i_cfg_data[PERIOD_BITS-1:0];
                CFG_MIN_INCLUSIVE:    r_cfg.min_period_inclusive <= i_cfg_data[0];
                CFG_MAX_PERIOD:       r_cfg.max_period_ms <= i_cfg_data[PERIOD_BITS-1:0];
                CFG_LOW_BPM:          r_cfg.low_bpm_limit <= i_cfg_data[RATE_BITS-1:0];
                CFG_HIGH_BPM:         r_cfg.high_bpm_limit <= i_cfg_data[RATE_BITS-1:0];
                CFG_ABNORMAL_MIN_PER: begin
                    r_cfg.abnormal_min_period_ms <= i_cfg_data[PERIOD_BITS-1:0];
                end
                default: ;
            endcase
        end
    end

    hrm_front #(
        .DEPTH (CMD_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .i_threshold (r_cfg.beat_threshold),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd       (w_cmd),
        .o_cmd_empty (w_cmd_empty)
    );

    hrm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (w_cmd),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    hrm_fifo #(
        .WIDTH ($bits(t_out_item)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_bits),
        .o_empty (empty)
    );

    assign o_result = t_out_item'(w_res_bits);

endmodule

// ----- design/hrm_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the heart rate monitor, bound to the top level.
// Depends on hrm_pkg and ecg_heart_rate_monitor_unit.
module hrm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                full,
    input logic                                empty,
    input logic                                pop,
    input hrm_pkg::t_out_item                  o_result
);
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("waiting result changed");

    a_beat_or_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_result.beat && o_result.lead_fault))
        else $error("beat and lead fault in one result");

    a_average_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.average_valid |-> !o_result.beat && !o_result.lead_fault)
        else $error("average reported on a sample result");

    a_average_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_result.average_valid |-> o_result.average_bpm == '0)
        else $error("average without a valid flag");

endmodule

bind ecg_heart_rate_monitor_unit hrm_checker u_hrm_checker (.*);
